// ===== rtl/msft_pkg.sv =====
// Shared types, codes and constants for the message stream framing tracker.
// No dependencies; used by msft_step and message_stream_framing_tracker_core.
package msft_pkg;

   localparam int unsigned LEN_W        = 21;
   localparam int unsigned WORD_W       = 32;
   localparam int unsigned REQ_DATA_W   = 120;
   localparam int unsigned RSP_DATA_W   = 48;

   localparam logic [LEN_W-1:0]  PAYLOAD_CAP  = LEN_W'(1024 * 1024);
   localparam logic [LEN_W-1:0]  HEADER_BYTES = LEN_W'(24);
   localparam logic [WORD_W-1:0] CONNECT_CMD  = 32'h4e584e43;
   localparam logic [WORD_W-1:0] ALL_ONES32   = 32'hffffffff;

   localparam logic [1:0] STREAM_SLOT = 2'd0;
   localparam logic [1:0] SLOT_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      REQ_HOST_XFER = 2'd0,
      REQ_BIND      = 2'd1,
      REQ_UNBIND    = 2'd2,
      REQ_REPLAY    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_NORMAL       = 3'd0,
      ST_LOST_SYNC    = 3'd1,
      ST_DROP_UNSYNC  = 3'd2,
      ST_RESYNC       = 3'd3,
      ST_TAIL_DROP    = 3'd4,
      ST_TAIL_END     = 3'd5,
      ST_BIND_REFUSED = 3'd6,
      ST_BIND_TAIL    = 3'd7
   } status_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [LEN_W-1:0]  transfer_len;
      logic [WORD_W-1:0] hdr_command;
      logic [WORD_W-1:0] hdr_payload_len;
      logic [WORD_W-1:0] hdr_magic;
      logic              bind_slot;
   } request_type;

   typedef struct packed {
      logic [LEN_W-1:0] payload_left;
      logic             drop_tail;
      logic             out_of_sync;
      logic             slot_bound;
      logic             attached_slot;
      logic [LEN_W-1:0] capture_left;
      logic [LEN_W-1:0] capture_len;
      logic             connect_seen;
      logic             record_present;
      logic [LEN_W-1:0] record_len;
   } track_state_type;

   typedef struct packed {
      logic             forward;
      status_type       status;
      logic             replay_due;
      logic             record_valid;
      logic [LEN_W-1:0] record_payload_len;
      logic [LEN_W-1:0] bytes_remaining;
   } result_type;

endpackage

// ===== rtl/msft_step.sv =====
// Per-request framing update: next tracker state and result from the current state.
// Depends on msft_pkg.
module msft_step
   import msft_pkg::*;
(
   input  track_state_type  state_cur,
   input  request_type      req,
   input  logic [LEN_W-1:0] max_len,
   output track_state_type  state_nxt,
   output result_type       result
);

   logic             on_stream;
   logic             replay_now;
   logic [LEN_W-1:0] limit;
   logic [LEN_W-1:0] take;
   logic [LEN_W-1:0] pl_after;
   logic [LEN_W-1:0] cl_after;
   logic             hdr_ok;
   logic             due_nxt;
   logic             fwd;
   status_type       st;
   track_state_type  ns;

   assign on_stream  = state_cur.slot_bound &&
                       ({1'b0, state_cur.attached_slot} == STREAM_SLOT);
   assign replay_now = on_stream && !state_cur.connect_seen && state_cur.record_present &&
                       (state_cur.payload_left == '0) && !state_cur.out_of_sync;
   assign limit      = (max_len > PAYLOAD_CAP) ? PAYLOAD_CAP : max_len;
   assign take       = (req.transfer_len < state_cur.payload_left) ?
                       req.transfer_len : state_cur.payload_left;
   assign pl_after   = state_cur.payload_left - take;
   assign cl_after   = (take < state_cur.capture_left) ? (state_cur.capture_left - take) : '0;
   assign hdr_ok     = (req.transfer_len == HEADER_BYTES) &&
                       (req.hdr_magic == (req.hdr_command ^ ALL_ONES32)) &&
                       (req.hdr_payload_len <= {{(WORD_W-LEN_W){1'b0}}, limit});

   always_comb begin
      ns  = state_cur;
      fwd = 1'b0;
      st  = ST_NORMAL;
      case (req.kind)
         REQ_HOST_XFER: begin
            fwd = 1'b1;
            if (on_stream && (req.transfer_len != '0)) begin
               if (state_cur.payload_left != '0) begin
                  ns.payload_left = pl_after;
                  if (state_cur.capture_left != '0) begin
                     ns.capture_left = cl_after;
                     if ((cl_after == '0) && !state_cur.drop_tail) begin
                        ns.record_present = 1'b1;
                        ns.record_len     = state_cur.capture_len;
                     end
                  end
                  fwd = !state_cur.drop_tail;
                  if (state_cur.drop_tail) begin
                     if (pl_after == '0) begin
                        ns.drop_tail = 1'b0;
                        st           = ST_TAIL_END;
                     end else begin
                        st = ST_TAIL_DROP;
                     end
                  end
               end else if (!hdr_ok) begin
                  st             = state_cur.out_of_sync ? ST_DROP_UNSYNC : ST_LOST_SYNC;
                  ns.out_of_sync = 1'b1;
                  fwd            = 1'b0;
               end else begin
                  if (state_cur.out_of_sync) begin
                     st             = ST_RESYNC;
                     ns.out_of_sync = 1'b0;
                  end
                  ns.payload_left = req.hdr_payload_len[LEN_W-1:0];
                  if (req.hdr_command == CONNECT_CMD) begin
                     ns.connect_seen = 1'b1;
                     ns.capture_left = req.hdr_payload_len[LEN_W-1:0];
                     ns.capture_len  = req.hdr_payload_len[LEN_W-1:0];
                     if (req.hdr_payload_len == '0) begin
                        ns.record_present = 1'b1;
                        ns.record_len     = '0;
                     end
                  end
               end
            end
         end
         REQ_BIND: begin
            if (state_cur.slot_bound || ({1'b0, req.bind_slot} >= SLOT_COUNT)) begin
               st = ST_BIND_REFUSED;
            end else begin
               ns.slot_bound    = 1'b1;
               ns.attached_slot = req.bind_slot;
               if ({1'b0, req.bind_slot} == STREAM_SLOT) begin
                  if (state_cur.payload_left != '0) begin
                     ns.drop_tail = 1'b1;
                     st           = ST_BIND_TAIL;
                  end
                  ns.connect_seen = 1'b0;
                  ns.capture_left = '0;
                  ns.capture_len  = '0;
               end
            end
         end
         REQ_UNBIND: begin
            ns.slot_bound = 1'b0;
         end
         REQ_REPLAY: begin
            if (replay_now) begin
               ns.connect_seen = 1'b1;
            end
         end
         default: begin
            ns = state_cur;
         end
      endcase
   end

   assign due_nxt = ns.slot_bound && ({1'b0, ns.attached_slot} == STREAM_SLOT) &&
                    !ns.connect_seen && ns.record_present &&
                    (ns.payload_left == '0) && !ns.out_of_sync;

   assign state_nxt                 = ns;
   assign result.forward            = fwd;
   assign result.status             = st;
   assign result.replay_due         = due_nxt;
   assign result.record_valid       = ns.record_present;
   assign result.record_payload_len = ns.record_len;
   assign result.bytes_remaining    = ns.payload_left;

endmodule

// ===== rtl/message_stream_framing_tracker_core.sv =====
// Top level of the message stream framing tracker: request register, state, result register.
// Depends on msft_pkg and msft_step.
//
// Usage:
//   req_*  : one request per handshake; req_tuser carries the request kind (host transfer,
//            bind, unbind, replay completed), req_tdata the transfer length, header words
//            and bind slot.
//   rsp_*  : one response per request, in order; rsp_tuser carries the status code,
//            rsp_tdata the forward flag, replay flag, record info and bytes remaining.
//   csr_*  : write of the payload length limit; always ready, write only while idle.
// Path: an accepted request sits in the request register; its response is registered for rsp_*.
// Throughput: one request per cycle while rsp_tready is high; the request and response
// registers hold one item each; the tracker state updates in the single step between them.
// Reset: all framing state clears, nothing is bound, the limit returns to 1048576.
// Stall: while rsp_tready is low the response holds, one more request can sit in the
// request register, and then req_tready drops until the response is taken.
module message_stream_framing_tracker_core
   import msft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [20:0] transfer_len, [52:21] hdr_command, [84:53] hdr_payload_len,
   // [116:85] hdr_magic, [117] bind_slot, [119:118] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] forward, [1] replay_due, [2] record_valid, [23:3] record_payload_len,
   // [44:24] bytes_remaining, [47:45] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_data
);

   logic             in_valid_ff, in_valid_in;
   request_type      in_req_ff, in_req_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_rsp_ff, out_rsp_in;
   track_state_type  state_ff, state_in;
   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic             out_load;
   logic             req_take;
   track_state_type  step_state;
   result_type       step_result;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   msft_step u_step (
      .state_cur (state_ff),
      .req       (in_req_ff),
      .max_len   (max_len_ff),
      .state_nxt (step_state),
      .result    (step_result)
   );

   always_comb begin
      in_req_in.kind            = req_kind_type'(req_tuser);
      in_req_in.transfer_len    = req_tdata[20:0];
      in_req_in.hdr_command     = req_tdata[52:21];
      in_req_in.hdr_payload_len = req_tdata[84:53];
      in_req_in.hdr_magic       = req_tdata[116:85];
      in_req_in.bind_slot       = req_tdata[117];
      if (!req_take) begin
         in_req_in = in_req_ff;
      end
   end

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   assign out_rsp_in   = out_load ? step_result : out_rsp_ff;
   assign state_in     = out_load ? step_state : state_ff;
   assign max_len_in   = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         max_len_ff   <= PAYLOAD_CAP;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         max_len_ff   <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rsp_ff.status;
   assign rsp_tdata  = {3'b000,
                        out_rsp_ff.bytes_remaining,
                        out_rsp_ff.record_payload_len,
                        out_rsp_ff.record_valid,
                        out_rsp_ff.replay_due,
                        out_rsp_ff.forward};

endmodule
